/* design/positional_ordered_list_unit_macros.svh */
// Assertion macros shared by the list unit's modules.
// Depends on nothing; the including module must have clk and arst_n in scope.
`ifndef POSITIONAL_ORDERED_LIST_UNIT_MACROS_SVH
`define POSITIONAL_ORDERED_LIST_UNIT_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define POL_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Checks that a condition is followed by an expectation in the next cycle.
`define POL_ASSERT_NEXT(label, cond, expect_expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(cond) |=> (expect_expr)) else $error(msg);

`endif

/* design/pol_pkg.sv */
// Package for the positional ordered list unit: sizes, operation codes, cell control.
// Depends on nothing; used by the interfaces, the cell and the top level.
package pol_pkg;

	localparam int DEPTH  = 32;
	localparam int DATA_W = 32;
	localparam int POS_W  = 6;
	localparam int MODE_W = 3;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT = 3'd0,
		MODE_DELETE = 3'd1,
		MODE_GET    = 3'd2,
		MODE_LOCATE = 3'd3,
		MODE_CLEAR  = 3'd4
	} pol_mode_t;

	// At most one of these is set for a cell in any cycle.
	typedef struct packed {
		logic load;
		logic from_left;
		logic from_right;
	} pol_cell_ctl_t;

endpackage

/* design/pol_if.sv */
// Handshake channels of the list unit: command in, response out.
// Depends on pol_pkg for field widths.
interface pol_cmd_if;
	logic                                valid;
	logic                                ready;
	logic [pol_pkg::MODE_W-1:0]          mode;
	logic [pol_pkg::POS_W-1:0]           position;
	logic signed [pol_pkg::DATA_W-1:0]   value;

	modport source (output valid, output mode, output position, output value, input ready);
	modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

interface pol_rsp_if;
	logic                                valid;
	logic                                ready;
	logic                                status;
	logic signed [pol_pkg::DATA_W-1:0]   data_out;
	logic [pol_pkg::POS_W-1:0]           found_index;
	logic [pol_pkg::POS_W-1:0]           length;
	logic                                empty_res;

	modport source (output valid, output status, output data_out, output found_index,
		output length, output empty_res, input ready);
	modport sink   (input valid, input status, input data_out, input found_index,
		input length, input empty_res, output ready);
endinterface

/* design/pol_cell.sv */
// One storage cell of the list chain: holds an entry, shifts with its neighbors.
// Depends on pol_pkg for the control struct and data width.
module pol_cell (
	input  logic                              clk,
	input  pol_pkg::pol_cell_ctl_t            ctl,
	input  logic signed [pol_pkg::DATA_W-1:0] left_data,
	input  logic signed [pol_pkg::DATA_W-1:0] right_data,
	input  logic signed [pol_pkg::DATA_W-1:0] value,
	output logic signed [pol_pkg::DATA_W-1:0] data,
	output logic                              hit
);

	logic signed [pol_pkg::DATA_W-1:0] entry_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			entry_q <= value;
		end else if (ctl.from_left) begin
			entry_q <= left_data;
		end else if (ctl.from_right) begin
			entry_q <= right_data;
		end
	end

	assign data = entry_q;
	assign hit  = (entry_q == value);

endmodule

/* design/positional_ordered_list_unit.sv */
// Positional ordered list unit: a chain of cells holding up to DEPTH signed entries.
// Depends on pol_pkg, pol_if, pol_cell and the assertion macro header.
//
// Usage:
//   cmd carries one operation per transfer: insert before a 1-based position,
//   delete at a position, get at a position, locate the first entry equal to
//   value, or clear. rsp returns exactly one result per command with status,
//   the read or removed element, the located index, the new length and an
//   empty flag.
//   Every operation finishes in the cycle of its transfer: all cells shift or
//   load in parallel and compare their entry with the command value at once.
//   The response is registered and shows up in the cycle after the command
//   transfer; throughput is one command per cycle while responses are taken.
//   The output register decides the rate: cmd.ready is high whenever that
//   register is empty or its response is taken in the same cycle, so a stalled
//   receiver holds the response and stops new commands after one.
//   Reset clears the entry count and the output valid flag. Entry contents are
//   not cleared; entries beyond the count are never reported.
`include "positional_ordered_list_unit_macros.svh"

module positional_ordered_list_unit (
	input  logic      clk,
	input  logic      arst_n,
	pol_cmd_if.sink   cmd,
	pol_rsp_if.source rsp
);

	localparam int DEPTH  = pol_pkg::DEPTH;
	localparam int DATA_W = pol_pkg::DATA_W;
	localparam int POS_W  = pol_pkg::POS_W;
	localparam int CNT_W  = pol_pkg::CNT_W;
	localparam int CMP_W  = pol_pkg::CMP_W;

	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          count_next;
	logic                      out_valid_q;
	logic                      status_q;
	logic signed [DATA_W-1:0]  data_q;
	logic [POS_W-1:0]          found_q;
	logic [POS_W-1:0]          length_q;
	logic                      empty_q;

	logic                      accept;
	pol_pkg::pol_mode_t        mode_e;
	logic [CMP_W-1:0]          pos_w;
	logic [CMP_W-1:0]          cnt_w;
	logic [CMP_W-1:0]          pos_idx;
	logic                      ins_ok;
	logic                      rd_ok;
	logic                      do_ins;
	logic                      do_del;
	logic                      status_c;
	logic signed [DATA_W-1:0]  data_c;
	logic [POS_W-1:0]          found_c;

	logic signed [DATA_W-1:0]  cell_data [DEPTH];
	logic signed [DATA_W-1:0]  sel_data  [DEPTH];
	pol_pkg::pol_cell_ctl_t    cell_ctl  [DEPTH];
	logic [DEPTH-1:0]          hit;
	logic [DEPTH-1:0]          live_hit;
	logic [DEPTH-1:0]          first_hit;
	logic signed [DATA_W-1:0]  read_data;

	assign accept    = cmd.valid && cmd.ready;
	assign cmd.ready = !out_valid_q || rsp.ready;
	assign mode_e    = pol_pkg::pol_mode_t'(cmd.mode);

	assign pos_w   = CMP_W'(cmd.position);
	assign cnt_w   = CMP_W'(count_q);
	assign pos_idx = pos_w - CMP_W'(1);
	assign ins_ok  = (pos_w != '0) && (pos_w <= cnt_w + CMP_W'(1)) && (cnt_w < CMP_W'(DEPTH));
	assign rd_ok   = (pos_w != '0) && (pos_w <= cnt_w);

	// Each cell decides from its own index whether it loads, shifts up or shifts down.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CMP_W-1:0] CELL_IDX = CMP_W'(i);
		logic signed [DATA_W-1:0] left_d;
		logic signed [DATA_W-1:0] right_d;

		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_inner_l
			assign left_d = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_inner_r
			assign right_d = cell_data[i+1];
		end

		always_comb begin
			cell_ctl[i].load       = accept && do_ins && (CELL_IDX == pos_idx);
			cell_ctl[i].from_left  = accept && do_ins && (CELL_IDX > pos_idx);
			cell_ctl[i].from_right = accept && do_del && (CELL_IDX >= pos_idx);
		end

		assign sel_data[i] = (CELL_IDX == pos_idx) ? cell_data[i] : '0;
		assign live_hit[i] = hit[i] && (CELL_IDX < cnt_w);

		pol_cell u_cell (
			.clk        (clk),
			.ctl        (cell_ctl[i]),
			.left_data  (left_d),
			.right_data (right_d),
			.value      (cmd.value),
			.data       (cell_data[i]),
			.hit        (hit[i])
		);
	end

	// Lowest live match wins.
	assign first_hit = live_hit & ~(live_hit - DEPTH'(1));

	always_comb begin
		read_data = '0;
		found_c   = '0;
		for (int i = 0; i < DEPTH; i++) begin
			read_data = read_data | sel_data[i];
			if (first_hit[i]) begin
				found_c = found_c | POS_W'(i + 1);
			end
		end
	end

	always_comb begin
		do_ins     = 1'b0;
		do_del     = 1'b0;
		status_c   = 1'b1;
		data_c     = '0;
		count_next = count_q;
		unique case (mode_e)
			pol_pkg::MODE_INSERT: begin
				do_ins   = ins_ok;
				status_c = !ins_ok;
				if (ins_ok) begin
					count_next = count_q + CNT_W'(1);
				end
			end
			pol_pkg::MODE_DELETE: begin
				do_del   = rd_ok;
				status_c = !rd_ok;
				if (rd_ok) begin
					data_c     = read_data;
					count_next = count_q - CNT_W'(1);
				end
			end
			pol_pkg::MODE_GET: begin
				status_c = !rd_ok;
				if (rd_ok) begin
					data_c = read_data;
				end
			end
			pol_pkg::MODE_LOCATE: begin
				status_c = 1'b0;
			end
			pol_pkg::MODE_CLEAR: begin
				status_c   = 1'b0;
				count_next = '0;
			end
			default: begin
				status_c = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_c;
			data_q   <= data_c;
			found_q  <= (mode_e == pol_pkg::MODE_LOCATE) ? found_c : '0;
			length_q <= POS_W'(count_next);
			empty_q  <= (count_next == '0);
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = status_q;
	assign rsp.data_out    = data_q;
	assign rsp.found_index = found_q;
	assign rsp.length      = length_q;
	assign rsp.empty_res   = empty_q;

	`POL_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH), "entry count exceeds depth")
	`POL_ASSERT_NEXT(a_ins_grows, accept && do_ins, count_q == $past(count_q) + CNT_W'(1), "insert did not grow the list")
	`POL_ASSERT_NEXT(a_del_shrinks, accept && do_del, count_q == $past(count_q) - CNT_W'(1), "delete did not shrink the list")
	`POL_ASSERT_NEXT(a_clear_empties, accept && (mode_e == pol_pkg::MODE_CLEAR), count_q == '0, "clear left entries")

endmodule

/* sim/tb_positional_ordered_list_unit.sv */
`timescale 1ns / 100ps
// Self-checking testbench for positional_ordered_list_unit: directed and random list operations.
// Depends on pol_pkg, pol_if and the unit itself; expected responses come from a shadow list.
module tb_positional_ordered_list_unit;

	localparam int DEPTH  = pol_pkg::DEPTH;
	localparam int DATA_W = pol_pkg::DATA_W;
	localparam int POS_W  = pol_pkg::POS_W;
	localparam int MODE_W = pol_pkg::MODE_W;

	localparam logic [MODE_W-1:0] MODE_UNUSED_FIRST = 3'd5;
	localparam logic [MODE_W-1:0] MODE_UNUSED_LAST  = 3'd7;
	localparam int RANDOM_ITEMS = 1650;
	localparam int QUIET_LIMIT  = 1000;
	localparam int MAX_PRINTS   = 30;

	typedef struct {
		logic [MODE_W-1:0]        mode;
		logic [POS_W-1:0]         position;
		logic signed [DATA_W-1:0] value;
		int                       gap;
		bit                       hold;
	} cmd_item_t;

	typedef struct {
		logic                     status;
		logic signed [DATA_W-1:0] data;
		logic [POS_W-1:0]         index;
		logic [POS_W-1:0]         len;
		logic                     empty;
	} list_result_t;

	logic clk;
	logic arst_n;

	pol_cmd_if cmd_ch();
	pol_rsp_if rsp_ch();

	positional_ordered_list_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the list contents and length.
	logic signed [DATA_W-1:0] list_vals [DEPTH];
	int                       list_len = 0;

	cmd_item_t    pending_q [$];
	list_result_t expected_q [$];

	int gen_len = 0;
	bit calm_send = 1'b0;
	int queued_cnt = 0;
	int sent_cnt = 0;
	int checked_cnt = 0;
	int mismatch_cnt = 0;
	int err_status_cnt = 0;
	int hit_cnt = 0;
	int full_rejects = 0;
	int peak_len = 0;
	int quiet_cycles = 0;

	int           idle_left;
	bit           armed;
	bit           go;
	cmd_item_t    head;
	int           stall_left;
	int           calm_left;
	list_result_t want;

	logic signed [DATA_W-1:0] value_pool [6] = '{32'sh7FFFFFFF, 32'sh80000000, -32'sd1,
		32'sd0, 32'sd1, 32'sh12345678};

	function automatic list_result_t list_apply(input logic [MODE_W-1:0] m,
			input logic [POS_W-1:0] p, input logic signed [DATA_W-1:0] v);
		list_result_t res;
		int at;
		at = p;
		res.status = 1'b1;
		res.data = '0;
		res.index = '0;
		case (m)
		pol_pkg::MODE_INSERT: begin
			if (at >= 1 && at <= list_len + 1 && list_len < DEPTH) begin
				for (int k = list_len; k >= at; k--)
					list_vals[k] = list_vals[k - 1];
				list_vals[at - 1] = v;
				list_len++;
				res.status = 1'b0;
			end else if (list_len == DEPTH) begin
				full_rejects++;
			end
		end
		pol_pkg::MODE_DELETE: begin
			if (at >= 1 && at <= list_len) begin
				res.data = list_vals[at - 1];
				for (int k = at; k < list_len; k++)
					list_vals[k - 1] = list_vals[k];
				list_len--;
				res.status = 1'b0;
			end
		end
		pol_pkg::MODE_GET: begin
			if (at >= 1 && at <= list_len) begin
				res.data = list_vals[at - 1];
				res.status = 1'b0;
			end
		end
		pol_pkg::MODE_LOCATE: begin
			res.status = 1'b0;
			for (int k = list_len - 1; k >= 0; k--)
				if (list_vals[k] == v)
					res.index = POS_W'(k + 1);
		end
		pol_pkg::MODE_CLEAR: begin
			list_len = 0;
			res.status = 1'b0;
		end
		default: begin
		end
		endcase
		res.len = POS_W'(list_len);
		res.empty = (list_len == 0);
		return res;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_cnt < MAX_PRINTS)
			$display("mismatch at %0t ns: %s", $realtime, msg);
		mismatch_cnt++;
	endtask

	task automatic check_field(input string name, input logic [DATA_W-1:0] got,
			input logic [DATA_W-1:0] exp_val);
		if (got !== exp_val)
			report_mismatch($sformatf("response %0d %s is %0h, expected %0h",
				checked_cnt, name, got, exp_val));
	endtask

	// Queues one command and keeps a running estimate of the length for shaping positions.
	task automatic queue_cmd(input logic [MODE_W-1:0] m, input logic [POS_W-1:0] p,
			input logic signed [DATA_W-1:0] v, input bit h);
		cmd_item_t it;
		it.mode = m;
		it.position = p;
		it.value = v;
		it.gap = calm_send ? 0 : $urandom_range(0, 6);
		it.hold = h;
		pending_q.push_back(it);
		queued_cnt++;
		case (m)
		pol_pkg::MODE_INSERT: if (p >= 1 && p <= gen_len + 1 && gen_len < DEPTH) gen_len++;
		pol_pkg::MODE_DELETE: if (p >= 1 && p <= gen_len) gen_len--;
		pol_pkg::MODE_CLEAR:  gen_len = 0;
		default: begin
		end
		endcase
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		if ($urandom_range(0, 1) == 0)
			return value_pool[$urandom_range(0, 5)];
		return $urandom;
	endfunction

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Command driver: a transfer updates the shadow list, then the next item is offered.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			cmd_ch.mode <= '0;
			cmd_ch.position <= '0;
			cmd_ch.value <= '0;
			idle_left = 0;
			armed = 1'b0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				expected_q.push_back(list_apply(cmd_ch.mode, cmd_ch.position, cmd_ch.value));
				sent_cnt++;
			end
			if (!(cmd_ch.valid && !cmd_ch.ready)) begin
				go = 1'b0;
				if (pending_q.size() != 0) begin
					if (!armed) begin
						idle_left = pending_q[0].gap;
						armed = 1'b1;
					end
					if (pending_q[0].hold && expected_q.size() != 0) begin
						// Held back until every outstanding response has been taken.
					end else if (idle_left > 0) begin
						idle_left--;
					end else begin
						go = 1'b1;
					end
				end
				if (go) begin
					head = pending_q.pop_front();
					armed = 1'b0;
					cmd_ch.valid <= 1'b1;
					cmd_ch.mode <= head.mode;
					cmd_ch.position <= head.position;
					cmd_ch.value <= head.value;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor: checks each transfer against the oldest expectation and draws stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left = 0;
			calm_left = 0;
		end else if (rsp_ch.valid && rsp_ch.ready) begin
			if (expected_q.size() == 0) begin
				report_mismatch("response arrived with no command outstanding");
			end else begin
				want = expected_q.pop_front();
				check_field("status", rsp_ch.status, want.status);
				check_field("data_out", rsp_ch.data_out, want.data);
				check_field("found_index", rsp_ch.found_index, want.index);
				check_field("length", rsp_ch.length, want.len);
				check_field("empty_res", rsp_ch.empty_res, want.empty);
				checked_cnt++;
				if (want.status) err_status_cnt++;
				if (want.index != 0) hit_cnt++;
				if (want.len > peak_len) peak_len = want.len;
			end
			if (calm_left > 0) begin
				calm_left--;
				stall_left = 0;
			end else begin
				if ($urandom_range(0, 19) == 0)
					calm_left = $urandom_range(10, 50);
				stall_left = $urandom_range(0, 6);
			end
			rsp_ch.ready <= (stall_left == 0);
		end else if (!rsp_ch.ready) begin
			if (stall_left > 1) begin
				stall_left--;
			end else begin
				stall_left = 0;
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
				$display("TB_ERROR");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int r;
		int round_len;
		int bias;
		int c_ins, c_del, c_get, c_loc, c_clr;
		int target;
		bit hold;
		bit first;
		logic [POS_W-1:0] p_any;
		logic [POS_W-1:0] p_sel;

		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.mode = '0;
		cmd_ch.position = '0;
		cmd_ch.value = '0;
		rsp_ch.ready = 1'b0;

		// Directed: empty list, bad positions, extremes, ends of the list, unused modes.
		queue_cmd(pol_pkg::MODE_GET, 6'd1, 32'sd0, 1'b0);
		queue_cmd(pol_pkg::MODE_DELETE, 6'd1, 32'sd0, 1'b0);
		queue_cmd(pol_pkg::MODE_LOCATE, 6'd0, 32'sd0, 1'b0);
		queue_cmd(pol_pkg::MODE_CLEAR, 6'd0, 32'sd0, 1'b0);
		queue_cmd(pol_pkg::MODE_INSERT, 6'd0, 32'sd5, 1'b0);
		queue_cmd(pol_pkg::MODE_INSERT, 6'd2, 32'sd5, 1'b0);
		queue_cmd(pol_pkg::MODE_INSERT, 6'd1, 32'sh7FFFFFFF, 1'b0);
		queue_cmd(pol_pkg::MODE_INSERT, 6'd1, 32'sh80000000, 1'b0);
		queue_cmd(pol_pkg::MODE_INSERT, 6'd3, -32'sd1, 1'b0);
		queue_cmd(pol_pkg::MODE_INSERT, 6'd2, 32'sd0, 1'b0);
		queue_cmd(pol_pkg::MODE_GET, 6'd4, 32'sd0, 1'b0);
		queue_cmd(pol_pkg::MODE_GET, 6'd5, 32'sd0, 1'b0);
		queue_cmd(pol_pkg::MODE_GET, 6'd0, 32'sd0, 1'b0);
		queue_cmd(pol_pkg::MODE_GET, 6'd63, 32'sd0, 1'b0);
		queue_cmd(pol_pkg::MODE_LOCATE, 6'd0, -32'sd1, 1'b0);
		queue_cmd(pol_pkg::MODE_LOCATE, 6'd63, 32'sd12345, 1'b0);
		queue_cmd(pol_pkg::MODE_LOCATE, 6'd0, 32'sh80000000, 1'b0);
		queue_cmd(pol_pkg::MODE_DELETE, 6'd5, 32'sd0, 1'b0);
		queue_cmd(pol_pkg::MODE_DELETE, 6'd0, 32'sd0, 1'b0);
		queue_cmd(pol_pkg::MODE_DELETE, 6'd4, 32'sd0, 1'b0);
		queue_cmd(pol_pkg::MODE_DELETE, 6'd1, 32'sd0, 1'b0);
		for (int m = MODE_UNUSED_FIRST; m <= MODE_UNUSED_LAST; m++)
			queue_cmd(MODE_W'(m), 6'd1, $urandom, 1'b0);
		queue_cmd(pol_pkg::MODE_CLEAR, 6'd63, $urandom, 1'b0);

		// Random rounds, each leaning toward filling, draining, or a mix.
		target = queued_cnt + RANDOM_ITEMS;
		first = 1'b1;
		while (queued_cnt < target) begin
			bias = $urandom_range(0, 3);
			calm_send = ($urandom_range(0, 4) == 0);
			round_len = (bias == 2) ? $urandom_range(50, 90) : $urandom_range(20, 80);
			case (bias)
			0: begin c_ins = 50; c_del = 20; c_get = 10; c_loc = 10; c_clr = 2; end
			1: begin c_ins = 15; c_del = 55; c_get = 10; c_loc = 12; c_clr = 2; end
			2: begin c_ins = 90; c_del = 3;  c_get = 3;  c_loc = 3;  c_clr = 0; end
			default: begin c_ins = 35; c_del = 25; c_get = 15; c_loc = 15; c_clr = 3; end
			endcase
			c_del += c_ins;
			c_get += c_del;
			c_loc += c_get;
			c_clr += c_loc;
			for (int i = 0; i < round_len && queued_cnt < target; i++) begin
				r = $urandom_range(0, 99);
				p_any = POS_W'($urandom_range(0, 63));
				hold = first || ($urandom_range(0, 149) == 0);
				first = 1'b0;
				if (r < c_ins) begin
					p_sel = ($urandom_range(0, 9) == 0) ? p_any
						: POS_W'($urandom_range(1, gen_len + 1));
					queue_cmd(pol_pkg::MODE_INSERT, p_sel, pick_value(), hold);
				end else if (r < c_get) begin
					if (gen_len > 0 && $urandom_range(0, 9) != 0)
						p_sel = POS_W'($urandom_range(1, gen_len));
					else
						p_sel = $urandom_range(0, 1) ? p_any : POS_W'(gen_len + 1);
					queue_cmd((r < c_del) ? pol_pkg::MODE_DELETE : pol_pkg::MODE_GET, p_sel,
						$urandom, hold);
				end else if (r < c_loc) begin
					queue_cmd(pol_pkg::MODE_LOCATE, p_any,
						($urandom_range(0, 9) < 7) ? value_pool[$urandom_range(0, 5)] : $urandom,
						hold);
				end else if (r < c_clr) begin
					queue_cmd(pol_pkg::MODE_CLEAR, p_any, $urandom, hold);
				end else begin
					queue_cmd(MODE_W'($urandom_range(MODE_UNUSED_FIRST, MODE_UNUSED_LAST)),
						p_any, $urandom, hold);
				end
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() != 0 || cmd_ch.valid) @(negedge clk);
		while (expected_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);

		$display("run covered %0d commands and %0d checked responses, %0d with error status",
			sent_cnt, checked_cnt, err_status_cnt);
		$display("locate hits %0d, inserts refused on a full list %0d, peak length %0d",
			hit_cnt, full_rejects, peak_len);
		if (mismatch_cnt == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches", mismatch_cnt);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
